// File: design/salu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack ALU package
// Shared types and constants for the stack-machine ALU and its checker.
// ----------------------------------------------------------------------------
package salu_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = 7;
	localparam int ITER_W = 5;
	localparam logic [ITER_W-1:0] ITER_LAST = 5'd31;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_SWAP = 3'd1,
		OP_ADD  = 3'd2,
		OP_SUB  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MUL  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_NEG_S,
		S_NEG_T,
		S_DIV_LOOP,
		S_DIV_FIX,
		S_MUL_LOOP,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

// File: design/salu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack ALU RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module salu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: design/stack_alu_binary_ops.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack ALU with binary operations
// Bounded operand stack of 32-bit words running push, swap, add, sub, div
// and mul. The top word lives in a register, the words below it in a RAM.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals
//  req      in         req_valid, req_ready, req_type, push_value
//  rsp      out        rsp_valid, rsp_ready, status, top_value, stack_count
//
// A push, a fault for a short or full stack or an unknown request goes straight
// to the response state; swap, add, sub and a division by zero pass an execute
// state first; mul adds a multiply loop, div two negate states, a divide loop
// and a fix-up state. Mul and div run 32 steps of one shared 34-bit adder.
// Reset empties the stack; the RAM itself is not cleared.
// A stalled response holds the block in its response state.
// ----------------------------------------------------------------------------
module stack_alu_binary_ops
	import salu_pkg::*;
#(
	parameter int STACK_ENTRIES = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  wire [2:0]            req_type,
	input  wire signed [31:0]    push_value,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output logic [1:0]           status,
	output logic signed [31:0]   top_value,
	output logic [6:0]           stack_count
);

	localparam int AW = $clog2(STACK_ENTRIES);
	localparam int DW = $clog2(STACK_ENTRIES + 1);

	state_t state_q, state_d;

	logic [DW-1:0]     depth_q;
	logic              depth_inc, depth_dec;
	op_t               op_q;
	status_t           st_q, st_d;
	logic              st_we;
	logic [WORD_W-1:0] top_q, top_d;
	logic              top_we;
	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic              neg_q;
	logic [ITER_W-1:0] iter_q;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [WORD_W-1:0] rsp_top_q;
	logic [CNT_W-1:0]  rsp_count_q;
	logic              rsp_load;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic [33:0]       add_a, add_b, add_sum;
	logic              add_sub;

	logic [DW-1:0]     depth_m1, depth_m2;
	logic              full, short;
	logic              accept;
	logic [WORD_W:0]   div_sh;
	logic [DW+6:0]     count_ext;

	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);
	assign full      = (depth_q >= DW'(STACK_ENTRIES));
	assign short     = (depth_q < DW'(2));
	assign accept    = req_valid && req_ready;
	assign div_sh    = {rem_q, quo_q[WORD_W-1]};
	assign ram_raddr = depth_m2[AW-1:0];

	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {33'd0, add_sub};

	salu_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (depth_inc) begin
				depth_q <= depth_q + DW'(1);
			end else if (depth_dec) begin
				depth_q <= depth_m1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		depth_inc = 1'b0;
		depth_dec = 1'b0;
		st_we     = 1'b0;
		st_d      = ST_OK;
		top_we    = 1'b0;
		top_d     = top_q;
		ram_we    = 1'b0;
		ram_waddr = depth_m1[AW-1:0];
		ram_wdata = top_q;
		rsp_load  = 1'b0;
		add_a     = {2'b00, ram_rdata};
		add_b     = {2'b00, top_q};
		add_sub   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					st_we   = 1'b1;
					state_d = S_RESP;
					case (op_t'(req_type))
						OP_PUSH: begin
							if (full) begin
								st_d = ST_FULL;
							end else begin
								ram_we    = (depth_q != '0);
								top_we    = 1'b1;
								top_d     = push_value;
								depth_inc = 1'b1;
							end
						end
						OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
							if (short) begin
								st_d = ST_SHORT;
							end else begin
								state_d = S_EXEC;
							end
						end
						default: begin
							st_d = ST_OK;
						end
					endcase
				end
			end
			S_EXEC: begin
				add_sub = (op_q == OP_SUB);
				state_d = S_RESP;
				case (op_q)
					OP_SWAP: begin
						ram_we    = 1'b1;
						ram_waddr = depth_m2[AW-1:0];
						top_we    = 1'b1;
						top_d     = ram_rdata;
					end
					OP_ADD, OP_SUB: begin
						top_we    = 1'b1;
						top_d     = add_sum[WORD_W-1:0];
						depth_dec = 1'b1;
					end
					OP_DIV: begin
						if (top_q == '0) begin
							st_we = 1'b1;
							st_d  = ST_DIVZERO;
						end else begin
							state_d = S_NEG_S;
						end
					end
					default: begin
						state_d = S_MUL_LOOP;
					end
				endcase
			end
			S_NEG_S: begin
				add_a   = '0;
				add_b   = {2'b00, quo_q};
				add_sub = 1'b1;
				state_d = S_NEG_T;
			end
			S_NEG_T: begin
				add_a   = '0;
				add_b   = {2'b00, dvs_q};
				add_sub = 1'b1;
				state_d = S_DIV_LOOP;
			end
			S_DIV_LOOP: begin
				add_a   = {1'b0, div_sh};
				add_b   = {2'b00, dvs_q};
				add_sub = 1'b1;
				if (iter_q == ITER_LAST) begin
					state_d = S_DIV_FIX;
				end
			end
			S_DIV_FIX: begin
				add_a     = '0;
				add_b     = {2'b00, quo_q};
				add_sub   = 1'b1;
				top_we    = 1'b1;
				top_d     = neg_q ? add_sum[WORD_W-1:0] : quo_q;
				depth_dec = 1'b1;
				state_d   = S_RESP;
			end
			S_MUL_LOOP: begin
				add_a = {2'b00, rem_q};
				add_b = {2'b00, dvs_q};
				if (iter_q == ITER_LAST) begin
					top_we    = 1'b1;
					top_d     = quo_q[0] ? add_sum[WORD_W-1:0] : rem_q;
					depth_dec = 1'b1;
					state_d   = S_RESP;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(req_type);
		end
		if (st_we) begin
			st_q <= st_d;
		end
		if (top_we) begin
			top_q <= top_d;
		end
		case (state_q)
			S_EXEC: begin
				neg_q  <= ram_rdata[WORD_W-1] ^ top_q[WORD_W-1];
				iter_q <= '0;
				rem_q  <= '0;
				if (op_q == OP_MUL) begin
					quo_q <= top_q;
					dvs_q <= ram_rdata;
				end else begin
					quo_q <= ram_rdata;
					dvs_q <= top_q;
				end
			end
			S_NEG_S: begin
				if (quo_q[WORD_W-1]) begin
					quo_q <= add_sum[WORD_W-1:0];
				end
			end
			S_NEG_T: begin
				if (dvs_q[WORD_W-1]) begin
					dvs_q <= add_sum[WORD_W-1:0];
				end
			end
			S_DIV_LOOP: begin
				iter_q <= iter_q + ITER_W'(1);
				quo_q  <= {quo_q[WORD_W-2:0], ~add_sum[33]};
				rem_q  <= add_sum[33] ? div_sh[WORD_W-1:0] : add_sum[WORD_W-1:0];
			end
			S_MUL_LOOP: begin
				iter_q <= iter_q + ITER_W'(1);
				quo_q  <= {1'b0, quo_q[WORD_W-1:1]};
				dvs_q  <= {dvs_q[WORD_W-2:0], 1'b0};
				if (quo_q[0]) begin
					rem_q <= add_sum[WORD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign count_ext = {7'd0, depth_q};

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= st_q;
			rsp_top_q    <= (depth_q == '0) ? '0 : top_q;
			rsp_count_q  <= count_ext[CNT_W-1:0];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign top_value   = rsp_top_q;
	assign stack_count = rsp_count_q;

endmodule
`default_nettype wire

// File: design/salu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack ALU checker
// Port-level assertions for the stack ALU, bound to its top level.
// ----------------------------------------------------------------------------
module salu_checker
	import salu_pkg::*;
#(
	parameter int STACK_ENTRIES = 64
) (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire [1:0]  status,
	input wire [31:0] top_value,
	input wire [6:0]  stack_count,
	input wire        rsp_valid,
	input wire        rsp_ready
);

	localparam bit SMALL = (STACK_ENTRIES < 128);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(top_value) && $stable(stack_count))
		else $error("response changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is in progress");

	a_short_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_SHORT |-> stack_count < 7'd2)
		else $error("stack too short reported with two or more words");

	a_divzero_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_DIVZERO |-> !SMALL || stack_count >= 7'd2)
		else $error("division by zero reported with fewer than two words");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && stack_count == 7'd0 && SMALL |-> top_value == 32'd0)
		else $error("empty stack reported a nonzero top word");

endmodule

bind stack_alu_binary_ops salu_checker #(
	.STACK_ENTRIES(STACK_ENTRIES)
) u_salu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.status     (status),
	.top_value  (top_value),
	.stack_count(stack_count),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready)
);
`default_nettype wire

// File: verif/tb_stack_alu_binary_ops.sv
// ----------------------------------------------------------------------------
// Stack ALU testbench
// Sends push, swap, arithmetic and reserved requests with random gaps on both
// channels. A shadow stack predicts every response, and status, top word and
// count are compared in order.
// ----------------------------------------------------------------------------
module tb_stack_alu_binary_ops
	import salu_pkg::*;
();

	localparam int STACK_ENTRIES = 64;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int MAX_REPORTS   = 50;

	localparam logic [2:0]  REQ_RSVD_A = 3'd6;
	localparam logic [2:0]  REQ_RSVD_B = 3'd7;
	localparam logic [31:0] WORD_MIN   = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX   = 32'h7fff_ffff;
	localparam logic [31:0] WORD_NEG1  = 32'hffff_ffff;

	typedef enum int {TREND_GROW, TREND_SHRINK, TREND_BALANCE} trend_t;

	typedef struct {
		status_t     st;
		logic [31:0] top;
		logic [6:0]  depth;
	} stack_rsp_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	wire  req_ready;
	logic [2:0] req_type;
	logic signed [31:0] push_value;
	wire  rsp_valid;
	logic rsp_ready;
	wire  [1:0] status;
	wire  signed [31:0] top_value;
	wire  [6:0] stack_count;

	logic [31:0] model_words [STACK_ENTRIES];
	int          model_depth;
	stack_rsp_t  expected_rsp [$];
	int          mismatches;
	int          quiet_cycles;
	bit          no_gaps;

	stack_alu_binary_ops #(.STACK_ENTRIES(STACK_ENTRIES)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.push_value  (push_value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.top_value   (top_value),
		.stack_count (stack_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void predict_request(logic [2:0] op, logic [31:0] value);
		stack_rsp_t  want;
		logic [31:0] s;
		logic [31:0] t;
		logic [31:0] r;
		longint      quot;
		want.st = ST_OK;
		case (op)
			OP_PUSH: begin
				if (model_depth >= STACK_ENTRIES) begin
					want.st = ST_FULL;
				end else begin
					model_words[model_depth] = value;
					model_depth++;
				end
			end
			OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
				if (model_depth < 2) begin
					want.st = ST_SHORT;
				end else begin
					t = model_words[model_depth-1];
					s = model_words[model_depth-2];
					if (op == OP_SWAP) begin
						model_words[model_depth-1] = s;
						model_words[model_depth-2] = t;
					end else if (op == OP_DIV && t == 32'd0) begin
						want.st = ST_DIVZERO;
					end else begin
						case (op)
							OP_ADD: r = s + t;
							OP_SUB: r = s - t;
							OP_MUL: r = s * t;
							default: begin
								quot = longint'($signed(s)) / longint'($signed(t));
								r = quot[31:0];
							end
						endcase
						model_words[model_depth-2] = r;
						model_depth--;
					end
				end
			end
			default: ;
		endcase
		want.top   = (model_depth > 0) ? model_words[model_depth-1] : 32'd0;
		want.depth = model_depth[6:0];
		expected_rsp.push_back(want);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return 32'd0;
			3: return WORD_NEG1;
			4: return 32'd1;
			5, 6: return 32'($signed($urandom_range(0, 16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_op(trend_t trend);
		int roll;
		int push_pct;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return ($urandom_range(0, 1) != 0) ? REQ_RSVD_A : REQ_RSVD_B;
		if (model_depth < 2 && $urandom_range(0, 3) != 0)
			return OP_PUSH;
		case (trend)
			TREND_GROW:   push_pct = 70;
			TREND_SHRINK: push_pct = 20;
			default:      push_pct = 45;
		endcase
		if ($urandom_range(0, 99) < push_pct)
			return OP_PUSH;
		return op_t'($urandom_range(OP_SWAP, OP_MUL));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at %0t: %s, got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// The request stays valid after acceptance so that a back-to-back request
	// needs no second update of valid in the same step.
	task automatic issue_request(logic [2:0] op, logic [31:0] value);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= op;
		push_value <= value;
		do @(posedge clk); while (!req_ready);
		predict_request(op, value);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_rsp.size() != 0);
	endtask

	task automatic test_short_stack();
		issue_request(OP_SWAP, pick_word());
		issue_request(OP_ADD, pick_word());
		issue_request(OP_SUB, pick_word());
		issue_request(OP_DIV, pick_word());
		issue_request(OP_MUL, pick_word());
		issue_request(REQ_RSVD_A, pick_word());
		issue_request(REQ_RSVD_B, pick_word());
		issue_request(OP_PUSH, 32'd5);
		issue_request(OP_ADD, pick_word());
		issue_request(OP_SWAP, pick_word());
		drain_responses();
	endtask

	task automatic test_arith_edges();
		issue_request(OP_PUSH, WORD_MAX);
		issue_request(OP_PUSH, 32'd1);
		issue_request(OP_ADD, 32'd0);
		issue_request(OP_PUSH, 32'd1);
		issue_request(OP_SUB, WORD_NEG1);
		issue_request(OP_PUSH, 32'd0);
		issue_request(OP_DIV, 32'd0);
		issue_request(OP_SWAP, 32'd0);
		issue_request(OP_SUB, 32'd0);
		issue_request(OP_PUSH, WORD_MIN);
		issue_request(OP_PUSH, WORD_NEG1);
		issue_request(OP_DIV, WORD_MAX);
		issue_request(OP_PUSH, 32'hffff_fff9);
		issue_request(OP_PUSH, 32'd2);
		issue_request(OP_DIV, 32'd0);
		issue_request(OP_PUSH, WORD_MAX);
		issue_request(OP_MUL, 32'd0);
		issue_request(REQ_RSVD_B, WORD_NEG1);
		drain_responses();
	endtask

	task automatic test_full_stack();
		while (model_depth < STACK_ENTRIES)
			issue_request(OP_PUSH, pick_word());
		issue_request(OP_PUSH, pick_word());
		issue_request(OP_PUSH, pick_word());
		issue_request(OP_SWAP, pick_word());
		while (model_depth >= 2)
			issue_request(op_t'($urandom_range(OP_SWAP, OP_MUL)), pick_word());
		issue_request(OP_DIV, pick_word());
		drain_responses();
	endtask

	task automatic test_random_mix();
		int     sent;
		int     seg_len;
		int     seg_count;
		trend_t trend;
		sent = 0;
		seg_count = 0;
		while (sent < RANDOM_ITEMS) begin
			trend   = trend_t'($urandom_range(TREND_GROW, TREND_BALANCE));
			seg_len = $urandom_range(20, 120);
			no_gaps = ($urandom_range(0, 4) == 0);
			repeat (seg_len) begin
				issue_request(pick_op(trend), pick_word());
				sent++;
			end
			seg_count++;
			if (seg_count % 4 == 0)
				drain_responses();
		end
		no_gaps = 1'b0;
		drain_responses();
	endtask

	initial begin : rsp_sink
		int stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	always @(posedge clk) begin : check_rsp
		stack_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("response with nothing pending", top_value, 32'd0);
			end else begin
				want = expected_rsp.pop_front();
				if (status !== want.st)
					report_mismatch("status", 32'(status), 32'(want.st));
				if (top_value !== want.top)
					report_mismatch("top_value", top_value, want.top);
				if (stack_count !== want.depth)
					report_mismatch("stack_count", 32'(stack_count), 32'(want.depth));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_type     = OP_PUSH;
		push_value   = 32'd0;
		model_depth  = 0;
		mismatches   = 0;
		quiet_cycles = 0;
		no_gaps      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_stack();
		test_arith_edges();
		test_full_stack();
		test_random_mix();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch("responses never arrived", expected_rsp.size(), 32'd0);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
